@@ hw/rtl/flow_table_lru_evictor_unit_macros.svh @@
// Assertion macros used by the flow table evictor RTL.
`ifndef FLOW_TABLE_LRU_EVICTOR_UNIT_MACROS_SVH
`define FLOW_TABLE_LRU_EVICTOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define FTLE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define FTLE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ftle_pkg.sv @@
// Types and constants shared by the flow table evictor modules.
package ftle_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT    = 3'd0,
    CFG_MEM_LIMIT  = 3'd1,
    CFG_MEM_LOW    = 3'd2,
    CFG_BYTE_CAP   = 3'd3,
    CFG_TRACE_SIZE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] timeout_us;
    logic [31:0] mem_limit_bytes;
    logic [31:0] mem_low_mark_bytes;
    logic [31:0] flow_byte_cap;
    logic [31:0] trace_file_bytes;
  } cfg_t;

  // Input word, first field in the highest bits and src_ip in the lowest.
  typedef struct packed {
    logic [15:0] capture_len;
    logic [47:0] timestamp_us;
    logic [7:0]  protocol;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
  } in_word_t;

  // Eviction record, first field in the highest bits and ev_src_ip in the lowest.
  typedef struct packed {
    logic [31:0] section_bytes;
    logic [31:0] file_offset;
    logic [31:0] file_index;
    logic [47:0] ev_last_time;
    logic [47:0] ev_first_time;
    logic [7:0]  ev_protocol;
    logic [15:0] ev_dst_port;
    logic [15:0] ev_src_port;
    logic [31:0] ev_dst_ip;
    logic [31:0] ev_src_ip;
  } out_rec_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_RD_HIT,
    OP_RD_OLD,
    OP_EVICT,
    OP_UNLINK,
    OP_APPEND,
    OP_UPDATE,
    OP_INSERT,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_done;
    logic cnt_nz;
    logic full;
    logic timed_out;
    logic ge_limit;
    logic ge_low;
    logic hit_newest;
    logic hit_oldest;
    logic out_free;
    logic pend_valid;
  } sts_t;

endpackage

@@ hw/rtl/flow_table_lru_evictor_unit.sv @@
// Flow table evictor top level: streams, configuration registers and checks.
//
// The block keeps up to MAX_FLOWS flows in on-chip memories, ordered from
// least to most recently used by a doubly linked list. A packet word (tuser
// low) is looked up by a sequential scan that reads one table entry per cycle;
// a hit then reads the flow, relinks it as the newest unless it already is,
// and updates its times and byte count. A miss walks the eviction phases from
// the oldest flow: timed-out flows, then flows under memory pressure, then the
// oldest flow of a full table, before the new flow is written. A flush word
// (tuser high) evicts every flow. Each eviction leaves one record word on the
// master side; the last record caused by an input word carries tlast. Records
// are held back one deep so that tlast can be set, and the walk stalls while
// the output register is occupied and not taken. A new input word is taken
// only when the previous one is complete. Configuration writes take effect at
// once and are meant for idle periods.
module flow_table_lru_evictor_unit #(
  parameter int unsigned MAX_FLOWS           = 64,
  parameter int unsigned RECORD_HEADER_BYTES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // src_ip, dst_ip, src_port, dst_port, protocol, timestamp_us, capture_len
  input  logic [167:0]                   s_axis_tdata,
  // kind
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // ev_src_ip, ev_dst_ip, ev_src_port, ev_dst_port, ev_protocol, ev_first_time,
  // ev_last_time, file_index, file_offset, section_bytes
  output logic [295:0]                   m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [ftle_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  `include "flow_table_lru_evictor_unit_macros.svh"

  ftle_pkg::cfg_t     cfg_q;
  ftle_pkg::cmd_t     cmd;
  ftle_pkg::sts_t     sts;
  ftle_pkg::out_rec_t out_rec;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us         <= 32'd60000000;
      cfg_q.mem_limit_bytes    <= 32'd67108864;
      cfg_q.mem_low_mark_bytes <= 32'd50331648;
      cfg_q.flow_byte_cap      <= 32'd1048576;
      cfg_q.trace_file_bytes   <= 32'd104857600;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ftle_pkg::CFG_TIMEOUT:    cfg_q.timeout_us         <= cfg_data_i;
        ftle_pkg::CFG_MEM_LIMIT:  cfg_q.mem_limit_bytes    <= cfg_data_i;
        ftle_pkg::CFG_MEM_LOW:    cfg_q.mem_low_mark_bytes <= cfg_data_i;
        ftle_pkg::CFG_BYTE_CAP:   cfg_q.flow_byte_cap      <= cfg_data_i;
        ftle_pkg::CFG_TRACE_SIZE: cfg_q.trace_file_bytes   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ftle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftle_dp #(
    .MAX_FLOWS           (MAX_FLOWS),
    .RECORD_HEADER_BYTES (RECORD_HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (ftle_pkg::in_word_t'(s_axis_tdata)),
    .in_kind_i   (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (out_rec),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_rec;

  // A new flow is only written once the table has room for it.
  `FTLE_ASSERT_IMP(a_insert_has_room, cmd.op == ftle_pkg::OP_INSERT, !sts.full,
                   "insert into a full flow table")
  // Evictions need a held flow and a free output path.
  `FTLE_ASSERT_IMP(a_evict_legal, cmd.op == ftle_pkg::OP_EVICT,
                   sts.cnt_nz && sts.out_free, "eviction without flow or output room")
  // Once a word is finished, no record is left waiting behind the output.
  `FTLE_ASSERT_IMP(a_idle_no_pending, s_axis_tready, !sts.pend_valid,
                   "idle with an undelivered eviction record")

endmodule

@@ hw/rtl/ftle_ctrl.sv @@
// Sequencer that walks one input word through lookup, hit update, eviction and insert, or through a flush.
module ftle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_kind_i,
  output logic           in_ready_o,
  input  ftle_pkg::sts_t sts_i,
  output ftle_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_HIT_RD, ST_HIT_CHK, ST_HIT_APP, ST_UPDATE,
    ST_EV_RD, ST_EV_CHK, ST_INSERT, ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    PH_FLUSH, PH_TIMEOUT, PH_PRESS_START, PH_PRESS, PH_FULL
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   want;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o.op   = ftle_pkg::OP_NONE;
    want       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ftle_pkg::OP_LOAD;
          if (in_kind_i) begin
            state_d = ST_EV_RD;
            phase_d = PH_FLUSH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.op = ftle_pkg::OP_SCAN;
        if (sts_i.scan_hit) begin
          state_d = ST_HIT_RD;
        end else if (sts_i.scan_done) begin
          state_d = ST_EV_RD;
          phase_d = PH_TIMEOUT;
        end
      end
      ST_HIT_RD: begin
        cmd_o.op = ftle_pkg::OP_RD_HIT;
        state_d  = ST_HIT_CHK;
      end
      ST_HIT_CHK: begin
        if (sts_i.hit_newest) begin
          state_d = ST_UPDATE;
        end else if (sts_i.hit_oldest) begin
          state_d = ST_HIT_APP;
        end else begin
          cmd_o.op = ftle_pkg::OP_UNLINK;
          state_d  = ST_HIT_APP;
        end
      end
      ST_HIT_APP: begin
        cmd_o.op = ftle_pkg::OP_APPEND;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.op = ftle_pkg::OP_UPDATE;
        state_d  = ST_FINISH;
      end
      ST_EV_RD: begin
        cmd_o.op = ftle_pkg::OP_RD_OLD;
        state_d  = ST_EV_CHK;
      end
      ST_EV_CHK: begin
        case (phase_q)
          PH_FLUSH: begin
            want = sts_i.cnt_nz;
            if (!want) state_d = ST_FINISH;
          end
          PH_TIMEOUT: begin
            want = sts_i.cnt_nz && sts_i.timed_out;
            if (!want) phase_d = PH_PRESS_START;
          end
          PH_PRESS_START: begin
            phase_d = (sts_i.cnt_nz && sts_i.ge_limit) ? PH_PRESS : PH_FULL;
          end
          PH_PRESS: begin
            want = sts_i.cnt_nz && sts_i.ge_low;
            if (!want) phase_d = PH_FULL;
          end
          PH_FULL: begin
            want = sts_i.full;
            if (!want) state_d = ST_INSERT;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
        if (want && sts_i.out_free) begin
          cmd_o.op = ftle_pkg::OP_EVICT;
          state_d  = (phase_q == PH_FULL) ? ST_INSERT : ST_EV_RD;
        end
      end
      ST_INSERT: begin
        cmd_o.op = ftle_pkg::OP_INSERT;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.op = ftle_pkg::OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_FLUSH;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

@@ hw/rtl/ftle_dp.sv @@
// Flow table storage, LRU links, byte and trace-file accounting, record output.
module ftle_dp #(
  parameter int unsigned MAX_FLOWS           = 64,
  parameter int unsigned RECORD_HEADER_BYTES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ftle_pkg::cfg_t     cfg_i,
  input  ftle_pkg::cmd_t     cmd_i,
  output ftle_pkg::sts_t     sts_o,
  input  ftle_pkg::in_word_t in_word_i,
  input  logic               in_kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ftle_pkg::out_rec_t out_rec_o,
  output logic               out_last_o
);

  localparam int unsigned IW = $clog2(MAX_FLOWS);
  localparam int unsigned CW = $clog2(MAX_FLOWS + 1);

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [47:0] first_time;
    logic [47:0] last_time;
    logic [31:0] bytes;
  } entry_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  entry_t        ent_mem   [MAX_FLOWS];
  logic [IW-1:0] older_mem [MAX_FLOWS];
  logic [IW-1:0] newer_mem [MAX_FLOWS];

  ftle_pkg::in_word_t in_q;
  logic [47:0]        latest_q;
  logic [MAX_FLOWS-1:0] valid_q;
  logic [IW-1:0]      oldest_q, newest_q, hit_idx_q, cmp_idx_q;
  logic [CW-1:0]      count_q;
  logic [31:0]        held_q, fnum_q, fpos_q;
  logic [IW:0]        scan_ctr_q;
  logic               cmp_v_q;
  entry_t             ent_q;
  logic [IW-1:0]      old_q, new_q;
  logic               pend_v_q, out_v_q, out_last_q;
  ftle_pkg::out_rec_t pend_q, out_q;

  ftle_pkg::op_e op;
  logic          scan_live, rd_en, match, out_free, file_wrap, out_load;
  logic [IW-1:0] rd_addr, free_idx;
  logic [31:0]   fwd, rev, add_bytes, pos_pre, num_pre;
  logic [47:0]   thr, ts;
  entry_t        upd_ent, ins_ent;
  ftle_pkg::out_rec_t rec;

  assign op        = cmd_i.op;
  assign ts        = in_q.timestamp_us;
  assign scan_live = (scan_ctr_q != (IW+1)'(MAX_FLOWS));
  assign fwd       = {in_q.src_port, in_q.dst_port};
  assign rev       = {in_q.dst_port, in_q.src_port};
  assign add_bytes = 32'(RECORD_HEADER_BYTES) + {16'd0, in_q.capture_len};
  assign out_free  = !out_v_q || out_ready_i;
  // The held-back record moves into the output register.
  assign out_load  = (op == ftle_pkg::OP_EVICT || op == ftle_pkg::OP_FINISH) && pend_v_q;

  assign match = cmp_v_q && (ent_q.proto == in_q.protocol) &&
                 ((ent_q.src_ip == in_q.src_ip && ent_q.dst_ip == in_q.dst_ip &&
                   ent_q.ports == fwd) ||
                  (ent_q.src_ip == in_q.dst_ip && ent_q.dst_ip == in_q.src_ip &&
                   ent_q.ports == rev));

  always_comb begin
    case (op)
      ftle_pkg::OP_SCAN:   rd_addr = scan_ctr_q[IW-1:0];
      ftle_pkg::OP_RD_HIT: rd_addr = hit_idx_q;
      default:             rd_addr = oldest_q;
    endcase
    rd_en = (op == ftle_pkg::OP_SCAN && scan_live) || op == ftle_pkg::OP_RD_HIT ||
            op == ftle_pkg::OP_RD_OLD;
  end

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_FLOWS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  assign thr = latest_q - {16'd0, cfg_i.timeout_us};

  always_comb begin
    sts_o.scan_hit   = match;
    sts_o.scan_done  = !scan_live && !match;
    sts_o.cnt_nz     = (count_q != '0);
    sts_o.full       = (count_q == CW'(MAX_FLOWS));
    sts_o.timed_out  = (latest_q >= {16'd0, cfg_i.timeout_us}) && (ent_q.last_time <= thr);
    sts_o.ge_limit   = (held_q >= cfg_i.mem_limit_bytes);
    sts_o.ge_low     = (held_q >= cfg_i.mem_low_mark_bytes);
    sts_o.hit_newest = (hit_idx_q == newest_q);
    sts_o.hit_oldest = (hit_idx_q == oldest_q);
    sts_o.out_free   = out_free;
    sts_o.pend_valid = pend_v_q;
  end

  // Eviction record for the oldest flow, with trace-file rollover.
  always_comb begin
    file_wrap         = (fpos_q >= cfg_i.trace_file_bytes);
    pos_pre           = file_wrap ? 32'd0 : fpos_q;
    num_pre           = file_wrap ? fnum_q + 32'd1 : fnum_q;
    rec.ev_src_ip     = ent_q.src_ip;
    rec.ev_dst_ip     = ent_q.dst_ip;
    rec.ev_src_port   = ent_q.ports[31:16];
    rec.ev_dst_port   = ent_q.ports[15:0];
    rec.ev_protocol   = ent_q.proto;
    rec.ev_first_time = ent_q.first_time;
    rec.ev_last_time  = ent_q.last_time;
    rec.file_index    = num_pre;
    rec.file_offset   = pos_pre;
    rec.section_bytes = ent_q.bytes;
  end

  always_comb begin
    upd_ent            = ent_q;
    upd_ent.first_time = (ent_q.first_time == '0) ? ts : ent_q.first_time;
    upd_ent.last_time  = (ent_q.last_time == '0 || ts > ent_q.last_time) ? ts :
                         ent_q.last_time;
    if (ent_q.bytes <= cfg_i.flow_byte_cap) upd_ent.bytes = sat_add(ent_q.bytes, add_bytes);
    ins_ent.src_ip     = in_q.src_ip;
    ins_ent.dst_ip     = in_q.dst_ip;
    ins_ent.ports      = fwd;
    ins_ent.proto      = in_q.protocol;
    ins_ent.first_time = ts;
    ins_ent.last_time  = ts;
    ins_ent.bytes      = add_bytes;
  end

  // Memories and read registers.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ent_q <= ent_mem[rd_addr];
      old_q <= older_mem[rd_addr];
      new_q <= newer_mem[rd_addr];
    end
    case (op)
      ftle_pkg::OP_UNLINK: begin
        newer_mem[old_q] <= new_q;
        older_mem[new_q] <= old_q;
      end
      ftle_pkg::OP_APPEND: begin
        older_mem[hit_idx_q] <= newest_q;
        newer_mem[newest_q]  <= hit_idx_q;
      end
      ftle_pkg::OP_UPDATE: begin
        ent_mem[hit_idx_q] <= upd_ent;
      end
      ftle_pkg::OP_INSERT: begin
        ent_mem[free_idx] <= ins_ent;
        if (count_q != '0) begin
          older_mem[free_idx] <= newest_q;
          newer_mem[newest_q] <= free_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (op == ftle_pkg::OP_LOAD) in_q <= in_word_i;
    if (op == ftle_pkg::OP_SCAN) cmp_idx_q <= scan_ctr_q[IW-1:0];
    if (op == ftle_pkg::OP_SCAN && match) hit_idx_q <= cmp_idx_q;
    if (op == ftle_pkg::OP_EVICT) pend_q <= rec;
    if (out_load) out_q <= pend_q;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q   <= '0;
      valid_q    <= '0;
      oldest_q   <= '0;
      newest_q   <= '0;
      count_q    <= '0;
      held_q     <= '0;
      fnum_q     <= '0;
      fpos_q     <= '0;
      scan_ctr_q <= '0;
      cmp_v_q    <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (op)
        ftle_pkg::OP_LOAD: begin
          scan_ctr_q <= '0;
          cmp_v_q    <= 1'b0;
          if (!in_kind_i && (latest_q == '0 || in_word_i.timestamp_us > latest_q)) begin
            latest_q <= in_word_i.timestamp_us;
          end
        end
        ftle_pkg::OP_SCAN: begin
          cmp_v_q <= scan_live && valid_q[scan_ctr_q[IW-1:0]];
          if (scan_live) scan_ctr_q <= scan_ctr_q + (IW+1)'(1);
        end
        ftle_pkg::OP_EVICT: begin
          fnum_q            <= num_pre;
          fpos_q            <= sat_add(pos_pre, ent_q.bytes);
          valid_q[oldest_q] <= 1'b0;
          count_q           <= count_q - CW'(1);
          held_q            <= (held_q >= ent_q.bytes) ? held_q - ent_q.bytes : 32'd0;
          if (oldest_q != newest_q) oldest_q <= new_q;
          pend_v_q          <= 1'b1;
          if (pend_v_q) out_last_q <= 1'b0;
        end
        ftle_pkg::OP_APPEND: begin
          if (hit_idx_q == oldest_q) oldest_q <= new_q;
          newest_q <= hit_idx_q;
        end
        ftle_pkg::OP_UPDATE: begin
          if (ent_q.bytes <= cfg_i.flow_byte_cap) held_q <= sat_add(held_q, add_bytes);
        end
        ftle_pkg::OP_INSERT: begin
          valid_q[free_idx] <= 1'b1;
          count_q           <= count_q + CW'(1);
          held_q            <= sat_add(held_q, add_bytes);
          newest_q          <= free_idx;
          if (count_q == '0) oldest_q <= free_idx;
        end
        ftle_pkg::OP_FINISH: begin
          if (pend_v_q) begin
            pend_v_q   <= 1'b0;
            out_last_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rec_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule
